/* design/ovrb_pkg.sv */
// ----------------------------------------------------------------------------
// ovrb_pkg
// Shared types and constants for the overwrite ring byte FIFO core.
// ----------------------------------------------------------------------------
package ovrb_pkg;

    // Default configuration of the core
    localparam int DEPTH_DEF    = 256;
    localparam int MAX_READ_DEF = 64;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Field widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int SIZE_W  = 9;
    localparam int USED_W  = 8;

    // Request codes
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_STATUS = 2'd2,
        MODE_FLUSH  = 2'd3
    } mode_t;

    // Classified request as it travels from front to back
    typedef struct packed {
        mode_t              mode;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

/* design/overwrite_ring_byte_fifo_core.sv */
// ----------------------------------------------------------------------------
// overwrite_ring_byte_fifo_core
// Byte ring buffer that overwrites its oldest byte when full.
// ----------------------------------------------------------------------------
// Requests enter a four-deep queue at up to one per cycle while the queue has room
// and are carried out by the back end in order. A status request yields one
// result. A read with a nonzero count that finds data is first set up in the idle
// state and then emits one byte per cycle, while the receiver is ready, from the
// ring store's registered read port; other reads yield one result. A write to the
// ring length register empties the ring and clears the overflow flag; the user
// must make it only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module overwrite_ring_byte_fifo_core #(
    parameter int DEPTH    = ovrb_pkg::DEPTH_DEF,
    parameter int MAX_READ = ovrb_pkg::MAX_READ_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ovrb_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [ovrb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [ovrb_pkg::COUNT_W-1:0] read_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ovrb_pkg::BYTE_W-1:0]  out_byte,
    output logic                         byte_valid,
    output logic                         last,
    output logic [ovrb_pkg::USED_W-1:0]  used_count,
    output logic                         overflow_seen
);

    logic           cmd_valid;
    logic           cmd_pop;
    ovrb_pkg::cmd_t cmd;

    // Accept configuration at any time
    assign cfg_ready = 1'b1;

    ovrb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .data_byte  (data_byte),
        .read_count (read_count),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    ovrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .last          (last),
        .used_count    (used_count),
        .overflow_seen (overflow_seen)
    );

endmodule

/* design/ovrb_front.sv */
// ----------------------------------------------------------------------------
// ovrb_front
// Accepts requests, clamps the read count and queues them for the back end.
// ----------------------------------------------------------------------------
module ovrb_front #(
    parameter int MAX_READ = ovrb_pkg::MAX_READ_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [ovrb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [ovrb_pkg::COUNT_W-1:0] read_count,
    output logic                         cmd_valid,
    output ovrb_pkg::cmd_t               cmd,
    input  logic                         cmd_pop
);

    localparam int QD = ovrb_pkg::QUEUE_DEPTH;
    localparam int AW = ovrb_pkg::QUEUE_AW;

    ovrb_pkg::cmd_t q_mem [QD];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    fill_reg, fill_next;
    ovrb_pkg::cmd_t new_cmd;
    logic           push;

    // Classify the incoming request
    always_comb
    begin
        new_cmd.mode  = ovrb_pkg::mode_t'(mode);
        new_cmd.data  = data_byte;
        new_cmd.count = (read_count > ovrb_pkg::COUNT_W'(MAX_READ))
                        ? ovrb_pkg::COUNT_W'(MAX_READ) : read_count;
    end

    assign in_ready  = (fill_reg != (AW+1)'(QD));
    assign push      = in_valid && in_ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QD-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QD-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + (AW+1)'(1);
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the request in the queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

/* design/ovrb_back.sv */
// ----------------------------------------------------------------------------
// ovrb_back
// Executes queued requests against the ring store and drives the result
// register.
// ----------------------------------------------------------------------------
module ovrb_back #(
    parameter int DEPTH = ovrb_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [ovrb_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                         cmd_valid,
    input  ovrb_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ovrb_pkg::BYTE_W-1:0]  out_byte,
    output logic                         byte_valid,
    output logic                         last,
    output logic [ovrb_pkg::USED_W-1:0]  used_count,
    output logic                         overflow_seen
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int CW        = (LEN_W > ovrb_pkg::SIZE_W) ? LEN_W : ovrb_pkg::SIZE_W;
    localparam int UW        = (LEN_W > ovrb_pkg::USED_W) ? LEN_W : ovrb_pkg::USED_W;
    localparam int RESET_LEN = (DEPTH < 256) ? DEPTH : 256;
    localparam int BW        = ovrb_pkg::BYTE_W;
    localparam int NW        = ovrb_pkg::COUNT_W;

    logic [BW-1:0]         store_mem [DEPTH];
    logic [BW-1:0]         rd_data_reg;

    ovrb_pkg::back_state_t state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic                  out_valid_reg;

    logic [LEN_W-1:0]      head_inc, tail_inc;
    logic [PTR_W-1:0]      head_adv, tail_adv;
    logic [UW-1:0]         used_wide;
    logic [CW-1:0]         size_wide;
    logic                  ring_empty, out_free, rd_last, start_read;
    logic                  wr_en, emit;
    logic [BW-1:0]         e_byte;
    logic                  e_valid, e_last, e_ovf;
    logic [ovrb_pkg::USED_W-1:0] e_used;

    // Pointer arithmetic, wrapping at the ring length
    assign head_inc   = LEN_W'(head_reg) + LEN_W'(1);
    assign tail_inc   = LEN_W'(tail_reg) + LEN_W'(1);
    assign head_adv   = (head_inc == len_reg) ? '0 : head_inc[PTR_W-1:0];
    assign tail_adv   = (tail_inc == len_reg) ? '0 : tail_inc[PTR_W-1:0];
    assign ring_empty = (head_reg == tail_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign rd_last    = (cnt_reg == NW'(1)) || (tail_adv == head_reg);
    assign start_read = cmd_valid && !cfg_valid && (state_reg == ovrb_pkg::BK_IDLE)
                        && (cmd.mode == ovrb_pkg::MODE_READ) && out_free
                        && (cmd.count != '0) && !ring_empty;

    // Bytes held in the ring
    always_comb
    begin
        if (head_reg >= tail_reg)
        begin
            used_wide = UW'(head_reg) - UW'(tail_reg);
        end
        else
        begin
            used_wide = UW'(len_reg) - UW'(tail_reg) + UW'(head_reg);
        end
    end

    // Clamp a written ring length into 2..DEPTH
    always_comb
    begin
        size_wide = CW'(cfg_data);
        if (size_wide < CW'(2))
        begin
            size_wide = CW'(2);
        end
        else if (size_wide > CW'(DEPTH))
        begin
            size_wide = CW'(DEPTH);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ovrb_pkg::BK_IDLE:
            begin
                if (start_read)
                begin
                    state_next = ovrb_pkg::BK_READ;
                end
            end
            ovrb_pkg::BK_READ:
            begin
                if (out_free && rd_last)
                begin
                    state_next = ovrb_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ovrb_pkg::BK_IDLE;
            end
        endcase
    end

    // Actions of the current state
    always_comb
    begin
        cmd_pop   = 1'b0;
        wr_en     = 1'b0;
        emit      = 1'b0;
        e_byte    = '0;
        e_valid   = 1'b0;
        e_last    = 1'b0;
        e_used    = '0;
        e_ovf     = 1'b0;
        head_next = head_reg;
        tail_next = tail_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        if (cfg_valid)
        begin
            len_next  = LEN_W'(size_wide);
            head_next = '0;
            tail_next = '0;
            ovf_next  = 1'b0;
        end
        else
        begin
            case (state_reg)
                ovrb_pkg::BK_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.mode)
                            ovrb_pkg::MODE_PUSH:
                            begin
                                cmd_pop   = 1'b1;
                                wr_en     = 1'b1;
                                head_next = head_adv;
                                // Drop the oldest byte when the head catches the tail
                                if (head_adv == tail_reg)
                                begin
                                    tail_next = tail_adv;
                                    ovf_next  = 1'b1;
                                end
                            end
                            ovrb_pkg::MODE_READ:
                            begin
                                if (out_free)
                                begin
                                    cmd_pop  = 1'b1;
                                    cnt_next = cmd.count;
                                    if ((cmd.count == '0) || ring_empty)
                                    begin
                                        emit   = 1'b1;
                                        e_last = 1'b1;
                                    end
                                end
                            end
                            ovrb_pkg::MODE_STATUS:
                            begin
                                if (out_free)
                                begin
                                    cmd_pop  = 1'b1;
                                    emit     = 1'b1;
                                    e_last   = 1'b1;
                                    e_used   = (used_wide > UW'(255)) ? 8'hFF
                                               : used_wide[ovrb_pkg::USED_W-1:0];
                                    e_ovf    = ovf_reg;
                                    ovf_next = 1'b0;
                                end
                            end
                            ovrb_pkg::MODE_FLUSH:
                            begin
                                cmd_pop   = 1'b1;
                                head_next = '0;
                                tail_next = '0;
                                ovf_next  = 1'b0;
                            end
                            default:
                            begin
                                cmd_pop = 1'b1;
                            end
                        endcase
                    end
                end
                ovrb_pkg::BK_READ:
                begin
                    // Emit one byte from the tail per cycle while the result register is free
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        e_byte    = rd_data_reg;
                        e_valid   = 1'b1;
                        e_last    = rd_last;
                        tail_next = tail_adv;
                        cnt_next  = cnt_reg - NW'(1);
                    end
                end
                default:
                begin
                    cmd_pop = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ovrb_pkg::BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= LEN_W'(RESET_LEN);
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte      <= e_byte;
            byte_valid    <= e_valid;
            last          <= e_last;
            used_count    <= e_used;
            overflow_seen <= e_ovf;
        end
    end

    // Ring store: write at head, prefetch the byte at the next tail
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[head_reg] <= cmd.data;
        end
        if (wr_en && (head_reg == tail_next))
        begin
            rd_data_reg <= cmd.data;
        end
        else
        begin
            rd_data_reg <= store_mem[tail_next];
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the overwrite ring byte FIFO core.
// ----------------------------------------------------------------------------
// A table of directed requests runs first: empty reads, zero and oversized
// read counts, status with and without overflow, flush, and ring lengths at
// the lower limit and beyond the upper one. Random phases follow, one per
// ring length, made mostly of push bursts followed by status and read
// requests. Each result is checked field by field against a behavioral copy
// of the ring kept here. Sender gaps and receiver stalls vary over the run.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 24;
    localparam int PLANNED_ITEMS = 344;
    localparam int RING_MAX      = ovrb_pkg::DEPTH_DEF;
    localparam int READ_MAX      = ovrb_pkg::MAX_READ_DEF;
    localparam longint TIMEOUT_NS = 64'd6_000_000;

    typedef struct packed {
        logic [ovrb_pkg::BYTE_W-1:0] out_byte;
        logic                        byte_valid;
        logic                        last;
        logic [ovrb_pkg::USED_W-1:0] used_count;
        logic                        overflow_seen;
    } ring_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        ovrb_pkg::mode_t              req_mode;
        logic [ovrb_pkg::BYTE_W-1:0]  data;
        logic [ovrb_pkg::COUNT_W-1:0] count;
        logic [ovrb_pkg::SIZE_W-1:0]  ring_len;
        logic                         typed;
        ring_result_t                 want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [ovrb_pkg::SIZE_W-1:0]   cfg_data      = '0;
    logic                          in_valid      = 1'b0;
    logic                          in_ready;
    logic [1:0]                    mode          = '0;
    logic [ovrb_pkg::BYTE_W-1:0]   data_byte     = '0;
    logic [ovrb_pkg::COUNT_W-1:0]  read_count    = '0;
    logic                          out_valid;
    logic                          out_ready     = 1'b0;
    logic [ovrb_pkg::BYTE_W-1:0]   out_byte;
    logic                          byte_valid;
    logic                          last;
    logic [ovrb_pkg::USED_W-1:0]   used_count;
    logic                          overflow_seen;

    // Shadow ring state
    logic [ovrb_pkg::BYTE_W-1:0]   ring_mem [RING_MAX];
    logic [ovrb_pkg::SIZE_W-1:0]   ring_cfg      = 9'd256;
    int                            ring_head     = 0;
    int                            ring_tail     = 0;
    logic                          ring_ovf      = 1'b0;

    ring_result_t        pending_results [$];
    stim_row_t           directed_rows [$];

    int                  send_idle_pct  = 13;
    int                  recv_stall_pct = 61;
    int                  error_count    = 0;
    int                  requests_sent  = 0;
    int                  cfg_writes     = 0;
    int                  results_seen   = 0;
    int                  bytes_seen     = 0;

    logic [ovrb_pkg::SIZE_W-1:0] phase_ring [8] = '{9'd0, 9'd2, 9'd3, 9'd7, 9'd16,
                                                    9'h1FF, 9'd256, 9'd0};
    int                  phase_budget [8] = '{30, 30, 30, 30, 30, 60, 60, 50};

    overwrite_ring_byte_fifo_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .data_byte     (data_byte),
        .read_count    (read_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .last          (last),
        .used_count    (used_count),
        .overflow_seen (overflow_seen)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("testbench: errors");
        $finish;
    end

    function automatic int ring_length();
        if (ring_cfg < 2)
            return 2;
        if (ring_cfg > RING_MAX)
            return RING_MAX;
        return ring_cfg;
    endfunction

    function automatic int next_slot(input int idx);
        return (idx + 1 >= ring_length()) ? 0 : idx + 1;
    endfunction

    function automatic ring_result_t single_result(input logic [7:0] b, input logic v,
                                                   input logic [7:0] u, input logic o);
        ring_result_t r;
        r.out_byte      = b;
        r.byte_valid    = v;
        r.last          = 1'b1;
        r.used_count    = u;
        r.overflow_seen = o;
        return r;
    endfunction

    // Apply one request to the shadow ring; queue its results when asked
    task automatic predict_request(input ovrb_pkg::mode_t m, input logic [7:0] d,
                                   input logic [6:0] cnt, input bit emit);
        int           want;
        int           n;
        int           used;
        int           after;
        ring_result_t r;
        r = '0;
        case (m)
            ovrb_pkg::MODE_PUSH:
            begin
                ring_mem[ring_head] = d;
                ring_head = next_slot(ring_head);
                if (ring_head == ring_tail)
                begin
                    ring_tail = next_slot(ring_tail);
                    ring_ovf  = 1'b1;
                end
            end
            ovrb_pkg::MODE_READ:
            begin
                want = (cnt > READ_MAX) ? READ_MAX : cnt;
                n    = 0;
                while (n < want && ring_head != ring_tail)
                begin
                    after        = next_slot(ring_tail);
                    r            = '0;
                    r.out_byte   = ring_mem[ring_tail];
                    r.byte_valid = 1'b1;
                    r.last       = (n == want - 1) || (after == ring_head);
                    if (emit)
                        pending_results.push_back(r);
                    ring_tail = after;
                    n++;
                end
                if (n == 0 && emit)
                    pending_results.push_back(single_result(8'h00, 1'b0, 8'd0, 1'b0));
            end
            ovrb_pkg::MODE_STATUS:
            begin
                if (ring_head >= ring_tail)
                    used = ring_head - ring_tail;
                else
                    used = ring_length() - ring_tail + ring_head;
                if (used > 255)
                    used = 255;
                if (emit)
                    pending_results.push_back(single_result(8'h00, 1'b0, used[7:0], ring_ovf));
                ring_ovf = 1'b0;
            end
            default:
            begin
                ring_head = 0;
                ring_tail = 0;
                ring_ovf  = 1'b0;
            end
        endcase
    endtask

    // Hand one request to the block, then predict it on acceptance
    task automatic send_request(input ovrb_pkg::mode_t m, input logic [7:0] d,
                                input logic [6:0] cnt, input bit typed,
                                input ring_result_t want);
        case (requests_sent * 3 / PLANNED_ITEMS)
            0:
            begin
                send_idle_pct  = 13;
                recv_stall_pct = 61;
            end
            1:
            begin
                send_idle_pct  = 61;
                recv_stall_pct = 13;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        data_byte  <= d;
        read_count <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(m, d, cnt, !typed);
        if (typed)
            pending_results.push_back(want);
        requests_sent++;
    endtask

    // Write the ring length once the block has gone quiet
    task automatic write_ring_len(input logic [ovrb_pkg::SIZE_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_cfg  = v;
        ring_head = 0;
        ring_tail = 0;
        ring_ovf  = 1'b0;
        cfg_writes++;
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Check each accepted result and drive random receiver stalls
    always @(posedge clk)
    begin
        ring_result_t got;
        ring_result_t exp_r;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            got = '{out_byte, byte_valid, last, used_count, overflow_seen};
            results_seen++;
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result %h", got));
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.byte_valid)
                    bytes_seen++;
                if (got.out_byte !== exp_r.out_byte)
                    flag_error($sformatf("out_byte %02h, want %02h",
                                         got.out_byte, exp_r.out_byte));
                if (got.byte_valid !== exp_r.byte_valid)
                    flag_error($sformatf("byte_valid %b, want %b",
                                         got.byte_valid, exp_r.byte_valid));
                if (got.last !== exp_r.last)
                    flag_error($sformatf("last %b, want %b", got.last, exp_r.last));
                if (got.used_count !== exp_r.used_count)
                    flag_error($sformatf("used_count %0d, want %0d",
                                         got.used_count, exp_r.used_count));
                if (got.overflow_seen !== exp_r.overflow_seen)
                    flag_error($sformatf("overflow_seen %b, want %b",
                                         got.overflow_seen, exp_r.overflow_seen));
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Stimulus: directed table, then random phases per ring length
    initial
    begin
        ring_result_t none;
        ring_result_t empty_rd;
        int           eff;
        int           issued;
        int           burst;
        int           pick;
        int           roll;
        logic [6:0]   cnt;
        logic [8:0]   len_val;

        none     = '0;
        empty_rd = single_result(8'h00, 1'b0, 8'd0, 1'b0);

        // Directed requests, starting from the reset ring length
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_STATUS, 8'h00, 7'd0, 9'd0, 1'b1,
                                  empty_rd});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'h00, 7'd5, 9'd0, 1'b1,
                                  empty_rd});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h00, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'hFF, 7'h7F, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'hA5, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'h00, 7'd0, 9'd0, 1'b1,
                                  empty_rd});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_STATUS, 8'h00, 7'd0, 9'd0, 1'b1,
                                  single_result(8'h00, 1'b0, 8'd3, 1'b0)});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'h00, 7'd1, 9'd0, 1'b1,
                                  single_result(8'h00, 1'b1, 8'd0, 1'b0)});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'hFF, 7'h7F, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'h00, 7'd64, 9'd0, 1'b1,
                                  empty_rd});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h5A, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_FLUSH, 8'h00, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_STATUS, 8'h00, 7'd0, 9'd0, 1'b1,
                                  empty_rd});
        directed_rows.push_back('{ROW_CFG, ovrb_pkg::MODE_PUSH, 8'h00, 7'd0, 9'd2, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h11, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h22, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_STATUS, 8'h00, 7'd0, 9'd0, 1'b1,
                                  single_result(8'h00, 1'b0, 8'd1, 1'b1)});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_STATUS, 8'h00, 7'd0, 9'd0, 1'b1,
                                  single_result(8'h00, 1'b0, 8'd1, 1'b0)});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'h00, 7'd2, 9'd0, 1'b1,
                                  single_result(8'h22, 1'b1, 8'd0, 1'b0)});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h33, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h44, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_CFG, ovrb_pkg::MODE_PUSH, 8'h00, 7'd0, 9'h1FF, 1'b0,
                                  none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_STATUS, 8'h00, 7'd0, 9'd0, 1'b1,
                                  empty_rd});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_PUSH, 8'h7F, 7'd0, 9'd0, 1'b0, none});
        directed_rows.push_back('{ROW_REQ, ovrb_pkg::MODE_READ, 8'h00, 7'h7F, 9'd0, 1'b1,
                                  single_result(8'h7F, 1'b1, 8'd0, 1'b0)});

        // Hold reset, then release on an edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_ring_len(directed_rows[i].ring_len);
            else
                send_request(directed_rows[i].req_mode, directed_rows[i].data,
                             directed_rows[i].count, directed_rows[i].typed,
                             directed_rows[i].want);
        end

        // Random phases: push bursts then status and reads, plus some noise
        foreach (phase_ring[p])
        begin
            len_val = (p == 7) ? 9'($urandom_range(2, 300)) : phase_ring[p];
            write_ring_len(len_val);
            eff    = ring_length();
            issued = 0;
            while (issued < phase_budget[p])
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    burst = $urandom_range(1, (eff + 1 > 80) ? 80 : eff + 1);
                    repeat (burst)
                        send_request(ovrb_pkg::MODE_PUSH, 8'($urandom_range(255)),
                                     7'($urandom_range(127)), 1'b0, none);
                    issued += burst;
                    if ($urandom_range(1))
                    begin
                        send_request(ovrb_pkg::MODE_STATUS, 8'($urandom_range(255)),
                                     7'($urandom_range(127)), 1'b0, none);
                        issued++;
                    end
                    repeat ($urandom_range(1, 2))
                    begin
                        roll = $urandom_range(99);
                        if (roll < 15)
                            cnt = 7'd0;
                        else if (roll < 40)
                            cnt = 7'($urandom_range(65, 127));
                        else
                            cnt = 7'($urandom_range(1, (eff < READ_MAX) ? eff : READ_MAX));
                        send_request(ovrb_pkg::MODE_READ, 8'($urandom_range(255)), cnt,
                                     1'b0, none);
                        issued++;
                    end
                end
                else if (pick < 90)
                begin
                    send_request(ovrb_pkg::mode_t'($urandom_range(3)),
                                 8'($urandom_range(255)),
                                 7'($urandom_range(127)), 1'b0, none);
                    issued++;
                end
                else
                begin
                    send_request($urandom_range(1) ? ovrb_pkg::MODE_FLUSH
                                                   : ovrb_pkg::MODE_STATUS,
                                 8'($urandom_range(255)), 7'($urandom_range(127)),
                                 1'b0, none);
                    issued++;
                end
            end
        end

        // Drain remaining results, then let the pipeline settle
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("coverage: %0d requests, %0d ring length writes", requests_sent, cfg_writes);
        $display("coverage: %0d results checked, %0d of them carrying bytes",
                 results_seen, bytes_seen);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* files.f */
design/ovrb_pkg.sv
design/ovrb_front.sv
design/ovrb_back.sv
design/overwrite_ring_byte_fifo_core.sv
dv/testbench.sv
